// ----- sv/nixie_clock_mux_driver_defines.svh -----
// Assertion macros for the nixie clock multiplexed display driver.
`ifndef NIXIE_CLOCK_MUX_DRIVER_DEFINES_SVH
`define NIXIE_CLOCK_MUX_DRIVER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define NXC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define NXC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/nxc_pkg.sv -----
// Shared types, operation codes and digit helpers for the nixie clock driver.
package nxc_pkg;

    localparam logic [2:0] OP_MUX_TICK    = 3'd0;
    localparam logic [2:0] OP_SECOND_TICK = 3'd1;
    localparam logic [2:0] OP_SET_TIME    = 3'd2;
    localparam logic [2:0] OP_HOUR_BUTTON = 3'd3;
    localparam logic [2:0] OP_MIN_BUTTON  = 3'd4;

    localparam logic [2:0] ANODE_DOT = 3'd4;

    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [5:0] SEC_MAX  = 6'd59;

    localparam logic [3:0] CATHODE_TABLE [10] = '{
        4'd0, 4'd9, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd3, 4'd6, 4'd5
    };

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       dot_on;
    } wall_t;

    typedef struct packed {
        logic [2:0] anode_select;
        logic       anode_on;
        logic [3:0] cathode_code;
    } disp_t;

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        priority if (v >= 6'd60) t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] rem;
        rem = v - 6'({2'b00, tens_of(v)} * 6'd10);
        return rem[3:0];
    endfunction

    function automatic logic [3:0] cathode_of(input logic [3:0] digit);
        logic [3:0] c;
        if (digit < 4'd10)
            c = CATHODE_TABLE[digit];
        else
            c = 4'd0;
        return c;
    endfunction

endpackage

// ----- sv/nixie_clock_mux_driver.sv -----
// Top level of the multiplexed nixie clock display driver.
//
// Command channel: cmd_valid / cmd_stall carry operation and the set_* fields.
// Result channel: res_valid / res_stall carry one result per command: the
// active anode, its drive level, the cathode code, the time and the dot target.
// A transaction completes on a rising edge with valid high and stall low.
// Each command is captured in an input register; once the result register is
// empty or its result is being taken, the command is applied to the clock and
// display state and its result is loaded into the result register, which
// presents it on the result channel.
// One command per cycle is sustained while res_stall stays low; the state
// update sits between the input and result registers.
// While res_stall holds, the result register keeps its transaction, one more
// command waits in the input register, and cmd_stall rises once both are full.
// Reset clears both stages, the time to 00:00:00, the dot target to on and the
// mux, PWM and dot brightness counters to zero.
`include "nixie_clock_mux_driver_defines.svh"

module nixie_clock_mux_driver #(
    parameter int PWM_PERIOD = 50,
    parameter int MUX_HOLD   = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [2:0] operation,
    input  logic [4:0] set_hours,
    input  logic [5:0] set_minutes,
    input  logic [5:0] set_seconds,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] anode_select,
    output logic       anode_on,
    output logic [3:0] cathode_code,
    output logic [4:0] hours,
    output logic [5:0] minutes,
    output logic [5:0] seconds,
    output logic       dot_on
);
    import nxc_pkg::*;

    logic       stage_valid_reg;
    logic [2:0] stage_op_reg;
    logic [4:0] stage_hours_reg;
    logic [5:0] stage_minutes_reg;
    logic [5:0] stage_seconds_reg;
    logic       res_valid_reg;
    wall_t      res_wall_reg;
    disp_t      res_disp_reg;

    logic  advance;
    logic  load;
    wall_t wall_cur;
    wall_t wall_nxt;
    disp_t disp_nxt;
    logic  stage_only;
    logic  time_ok;

    assign advance   = stage_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = stage_valid_reg && !advance;
    assign load      = cmd_valid && !cmd_stall;

    nxc_time u_time (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .operation   (stage_op_reg),
        .set_hours   (stage_hours_reg),
        .set_minutes (stage_minutes_reg),
        .set_seconds (stage_seconds_reg),
        .cur         (wall_cur),
        .nxt         (wall_nxt)
    );

    nxc_display #(
        .PWM_PERIOD (PWM_PERIOD),
        .MUX_HOLD   (MUX_HOLD)
    ) u_display (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .operation (stage_op_reg),
        .wall      (wall_cur),
        .nxt       (disp_nxt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (load)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_op_reg      <= operation;
            stage_hours_reg   <= set_hours;
            stage_minutes_reg <= set_minutes;
            stage_seconds_reg <= set_seconds;
        end
        if (advance)
        begin
            res_wall_reg <= wall_nxt;
            res_disp_reg <= disp_nxt;
        end
    end

    assign res_valid    = res_valid_reg;
    assign anode_select = res_disp_reg.anode_select;
    assign anode_on     = res_disp_reg.anode_on;
    assign cathode_code = res_disp_reg.cathode_code;
    assign hours        = res_wall_reg.hours;
    assign minutes      = res_wall_reg.minutes;
    assign seconds      = res_wall_reg.seconds;
    assign dot_on       = res_wall_reg.dot_on;

    assign stage_only = stage_valid_reg && !res_valid_reg;
    assign time_ok    = (wall_cur.hours <= HOUR_MAX) && (wall_cur.minutes <= MIN_MAX) &&
                        (wall_cur.seconds <= SEC_MAX);

    `NXC_ASSERT_NOW(a_stall_needs_stage, clk, rst_n, cmd_stall, stage_valid_reg && res_valid_reg)
    `NXC_ASSERT_NEXT(a_empty_result_fills, clk, rst_n, stage_only, res_valid_reg)
    `NXC_ASSERT_NOW(a_time_in_range, clk, rst_n, 1'b1, time_ok)
    `NXC_ASSERT_NOW(a_anode_in_range, clk, rst_n, res_valid_reg, anode_select <= ANODE_DOT)

endmodule

// ----- sv/nxc_time.sv -----
// Time-of-day counter with set, buttons and the blinking dot target.
module nxc_time (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [2:0]    operation,
    input  logic [4:0]    set_hours,
    input  logic [5:0]    set_minutes,
    input  logic [5:0]    set_seconds,
    output nxc_pkg::wall_t cur,
    output nxc_pkg::wall_t nxt
);
    import nxc_pkg::*;

    wall_t wall_reg;
    wall_t wall_next;

    always_comb
    begin
        wall_next = wall_reg;
        if (en)
        begin
            unique case (operation)
                OP_SECOND_TICK:
                begin
                    wall_next.dot_on = ~wall_reg.dot_on;
                    if (wall_reg.seconds < SEC_MAX)
                    begin
                        wall_next.seconds = wall_reg.seconds + 6'd1;
                    end
                    else
                    begin
                        wall_next.seconds = 6'd0;
                        if (wall_reg.minutes < MIN_MAX)
                        begin
                            wall_next.minutes = wall_reg.minutes + 6'd1;
                        end
                        else
                        begin
                            wall_next.minutes = 6'd0;
                            if (wall_reg.hours < HOUR_MAX)
                                wall_next.hours = wall_reg.hours + 5'd1;
                            else
                                wall_next.hours = 5'd0;
                        end
                    end
                end
                OP_SET_TIME:
                begin
                    wall_next.hours   = (set_hours > HOUR_MAX) ? HOUR_MAX : set_hours;
                    wall_next.minutes = (set_minutes > MIN_MAX) ? MIN_MAX : set_minutes;
                    wall_next.seconds = (set_seconds > SEC_MAX) ? SEC_MAX : set_seconds;
                end
                OP_HOUR_BUTTON:
                begin
                    wall_next.hours = (wall_reg.hours < HOUR_MAX) ?
                                      wall_reg.hours + 5'd1 : 5'd0;
                end
                OP_MIN_BUTTON:
                begin
                    wall_next.minutes = (wall_reg.minutes < MIN_MAX) ?
                                        wall_reg.minutes + 6'd1 : 6'd0;
                end
                default:
                begin
                    wall_next = wall_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_reg <= '{hours: 5'd0, minutes: 6'd0, seconds: 6'd0, dot_on: 1'b1};
        end
        else
        begin
            wall_reg <= wall_next;
        end
    end

    assign cur = wall_reg;
    assign nxt = wall_next;

endmodule

// ----- sv/nxc_display.sv -----
// Anode multiplexer, PWM brightness and cathode code generation.
module nxc_display #(
    parameter int PWM_PERIOD = 50,
    parameter int MUX_HOLD   = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [2:0]     operation,
    input  nxc_pkg::wall_t wall,
    output nxc_pkg::disp_t nxt
);
    import nxc_pkg::*;

    localparam logic [5:0] PWM_TOP  = 6'(PWM_PERIOD);
    localparam logic [5:0] DOT_FULL = 6'(PWM_PERIOD * 2 / 3);
    localparam logic [6:0] PWM_END  = 7'(PWM_PERIOD);
    localparam logic [7:0] HOLD_TOP = 8'(MUX_HOLD);

    logic [5:0] pwm_count_reg,   pwm_count_next;
    logic [5:0] pwm_compare_reg, pwm_compare_next;
    logic [5:0] dot_level_reg,   dot_level_next;
    logic [7:0] mux_count_reg,   mux_count_next;
    logic [2:0] anode_index_reg, anode_index_next;
    logic [3:0] cathode_reg,     cathode_next;

    logic [6:0] pwm_inc;
    logic [2:0] anode_step;
    logic       drive;
    logic [3:0] digit;

    assign pwm_inc    = {1'b0, pwm_count_reg} + 7'd1;
    assign anode_step = (anode_index_reg < ANODE_DOT) ? anode_index_reg + 3'd1 : 3'd0;

    always_comb
    begin
        unique case (anode_step[1:0])
            2'd0:    digit = tens_of({1'b0, wall.hours});
            2'd1:    digit = units_of({1'b0, wall.hours});
            2'd2:    digit = tens_of(wall.minutes);
            default: digit = units_of(wall.minutes);
        endcase
    end

    always_comb
    begin
        pwm_count_next   = pwm_count_reg;
        pwm_compare_next = pwm_compare_reg;
        dot_level_next   = dot_level_reg;
        mux_count_next   = mux_count_reg;
        anode_index_next = anode_index_reg;
        cathode_next     = cathode_reg;
        drive            = 1'b0;
        if (en && operation == OP_MUX_TICK)
        begin
            drive = (pwm_inc < {1'b0, pwm_compare_reg});
            pwm_count_next = (pwm_inc >= PWM_END) ? 6'd0 : pwm_inc[5:0];
            if (mux_count_reg < HOLD_TOP)
            begin
                mux_count_next = mux_count_reg + 8'd1;
            end
            else
            begin
                mux_count_next   = 8'd0;
                drive            = 1'b0;
                anode_index_next = anode_step;
                if (anode_step < ANODE_DOT)
                begin
                    cathode_next     = cathode_of(digit);
                    pwm_compare_next = PWM_TOP;
                end
                else
                begin
                    if (wall.dot_on)
                    begin
                        if (dot_level_reg < DOT_FULL)
                            dot_level_next = dot_level_reg + 6'd1;
                    end
                    else if (dot_level_reg > 6'd0)
                    begin
                        dot_level_next = dot_level_reg - 6'd1;
                    end
                    pwm_compare_next = dot_level_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg   <= 6'd0;
            pwm_compare_reg <= 6'd0;
            dot_level_reg   <= 6'd0;
            mux_count_reg   <= 8'd0;
            anode_index_reg <= 3'd0;
            cathode_reg     <= 4'd0;
        end
        else
        begin
            pwm_count_reg   <= pwm_count_next;
            pwm_compare_reg <= pwm_compare_next;
            dot_level_reg   <= dot_level_next;
            mux_count_reg   <= mux_count_next;
            anode_index_reg <= anode_index_next;
            cathode_reg     <= cathode_next;
        end
    end

    assign nxt.anode_select = anode_index_next;
    assign nxt.anode_on     = drive;
    assign nxt.cathode_code = cathode_next;

endmodule

// ----- sim/nixie_clock_mux_driver_tb.sv -----
// Self-checking testbench for the nixie clock multiplexed display driver.
`timescale 1ns / 100ps

module nixie_clock_mux_driver_tb;

    import nxc_pkg::*;

    localparam int PWM_PERIOD   = 50;
    localparam int MUX_HOLD     = 128;
    localparam int DOT_FULL     = PWM_PERIOD * 2 / 3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [3:0] DIGIT_MAP [10] = '{
        4'd0, 4'd9, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd3, 4'd6, 4'd5
    };

    typedef struct packed {
        logic [2:0] anode_select;
        logic       anode_on;
        logic [3:0] cathode_code;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       dot_on;
    } display_result_t;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    logic [2:0] operation;
    logic [4:0] set_hours;
    logic [5:0] set_minutes;
    logic [5:0] set_seconds;
    logic       res_valid;
    logic       res_stall;
    logic [2:0] anode_select;
    logic       anode_on;
    logic [3:0] cathode_code;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       dot_on;

    // Predicted clock and display state
    logic [4:0] pred_hours       = '0;
    logic [5:0] pred_minutes     = '0;
    logic [5:0] pred_seconds     = '0;
    logic       pred_dot_on      = 1'b1;
    logic [5:0] pred_dot_level   = '0;
    logic [5:0] pred_pwm_count   = '0;
    logic [5:0] pred_pwm_compare = '0;
    logic [7:0] pred_mux_count   = '0;
    logic [2:0] pred_anode       = '0;
    logic [3:0] pred_cathode     = '0;

    display_result_t pending_results [$];
    int  fail_count  = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  send_calm   = 1'b0;
    bit  recv_calm   = 1'b0;

    nixie_clock_mux_driver #(
        .PWM_PERIOD (PWM_PERIOD),
        .MUX_HOLD   (MUX_HOLD)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .operation    (operation),
        .set_hours    (set_hours),
        .set_minutes  (set_minutes),
        .set_seconds  (set_seconds),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .anode_select (anode_select),
        .anode_on     (anode_on),
        .cathode_code (cathode_code),
        .hours        (hours),
        .minutes      (minutes),
        .seconds      (seconds),
        .dot_on       (dot_on)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [3:0] tube_cathode(input logic [2:0] tube);
        int digit;
        case (tube)
            3'd0:    digit = int'(pred_hours) / 10;
            3'd1:    digit = int'(pred_hours) % 10;
            3'd2:    digit = int'(pred_minutes) / 10;
            default: digit = int'(pred_minutes) % 10;
        endcase
        return (digit < 10) ? DIGIT_MAP[digit] : 4'd0;
    endfunction

    function automatic logic run_mux_tick();
        logic drive;
        drive = (int'(pred_pwm_count) + 1 < int'(pred_pwm_compare));
        if (int'(pred_pwm_count) + 1 >= PWM_PERIOD)
            pred_pwm_count = '0;
        else
            pred_pwm_count = pred_pwm_count + 6'd1;
        if (int'(pred_mux_count) < MUX_HOLD)
        begin
            pred_mux_count = pred_mux_count + 8'd1;
            return drive;
        end
        // Switch tick: blank the old anode and move to the next one
        pred_mux_count = '0;
        pred_anode = (pred_anode < ANODE_DOT) ? pred_anode + 3'd1 : 3'd0;
        if (pred_anode < ANODE_DOT)
        begin
            pred_cathode     = tube_cathode(pred_anode);
            pred_pwm_compare = 6'(PWM_PERIOD);
        end
        else
        begin
            if (pred_dot_on)
            begin
                if (int'(pred_dot_level) < DOT_FULL)
                    pred_dot_level = pred_dot_level + 6'd1;
            end
            else if (pred_dot_level > 6'd0)
                pred_dot_level = pred_dot_level - 6'd1;
            pred_pwm_compare = pred_dot_level;
        end
        return 1'b0;
    endfunction

    function automatic void advance_second();
        pred_dot_on = ~pred_dot_on;
        if (pred_seconds < SEC_MAX)
            pred_seconds = pred_seconds + 6'd1;
        else
        begin
            pred_seconds = '0;
            if (pred_minutes < MIN_MAX)
                pred_minutes = pred_minutes + 6'd1;
            else
            begin
                pred_minutes = '0;
                pred_hours = (pred_hours < HOUR_MAX) ? pred_hours + 5'd1 : 5'd0;
            end
        end
    endfunction

    function automatic display_result_t predict_display(input logic [2:0] op,
                                                        input logic [4:0] sh,
                                                        input logic [5:0] sm,
                                                        input logic [5:0] ss);
        display_result_t r;
        logic drive;
        drive = 1'b0;
        case (op)
            OP_MUX_TICK:    drive = run_mux_tick();
            OP_SECOND_TICK: advance_second();
            OP_SET_TIME:
            begin
                pred_hours   = (sh > HOUR_MAX) ? HOUR_MAX : sh;
                pred_minutes = (sm > MIN_MAX) ? MIN_MAX : sm;
                pred_seconds = (ss > SEC_MAX) ? SEC_MAX : ss;
            end
            OP_HOUR_BUTTON: pred_hours = (pred_hours < HOUR_MAX) ? pred_hours + 5'd1 : 5'd0;
            OP_MIN_BUTTON:  pred_minutes = (pred_minutes < MIN_MAX) ? pred_minutes + 6'd1 : 6'd0;
            default: ;
        endcase
        r.anode_select = pred_anode;
        r.anode_on     = drive;
        r.cathode_code = pred_cathode;
        r.hours        = pred_hours;
        r.minutes      = pred_minutes;
        r.seconds      = pred_seconds;
        r.dot_on       = pred_dot_on;
        return r;
    endfunction

    function automatic int pick_idle_len(inout bit calm);
        int r;
        if ($urandom_range(0, 99) == 0)
            calm = ~calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [4:0] sh,
                            input logic [5:0] sm, input logic [5:0] ss);
        int gap;
        gap = pick_idle_len(send_calm);
        @(negedge clk);
        repeat (gap)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid   = 1'b1;
        operation   = op;
        set_hours   = sh;
        set_minutes = sm;
        set_seconds = ss;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_results.push_back(predict_display(op, sh, sm, ss));
    endtask

    task automatic test_reset_state();
        send_cmd(OP_SPARE_5, 5'd31, 6'd63, 6'd63);
        send_cmd(OP_SPARE_6, 5'd0, 6'd0, 6'd0);
        send_cmd(OP_SPARE_7, 5'd31, 6'd63, 6'd63);
    endtask

    task automatic test_set_time_clamp();
        send_cmd(OP_SET_TIME, 5'd31, 6'd63, 6'd63);
        send_cmd(OP_SET_TIME, 5'd0, 6'd0, 6'd0);
        send_cmd(OP_SET_TIME, 5'd23, 6'd59, 6'd59);
    endtask

    task automatic test_time_rollover();
        send_cmd(OP_SECOND_TICK, 5'd31, 6'd63, 6'd63);
        send_cmd(OP_SET_TIME, 5'd22, 6'd59, 6'd59);
        send_cmd(OP_SECOND_TICK, 5'd0, 6'd0, 6'd0);
        send_cmd(OP_SECOND_TICK, 5'd0, 6'd0, 6'd0);
    endtask

    task automatic test_buttons();
        send_cmd(OP_SET_TIME, 5'd23, 6'd59, 6'd0);
        send_cmd(OP_HOUR_BUTTON, 5'd31, 6'd63, 6'd63);
        send_cmd(OP_MIN_BUTTON, 5'd31, 6'd63, 6'd63);
        send_cmd(OP_HOUR_BUTTON, 5'd0, 6'd0, 6'd0);
        send_cmd(OP_MIN_BUTTON, 5'd0, 6'd0, 6'd0);
    endtask

    task automatic test_mux_ticks();
        send_cmd(OP_MUX_TICK, 5'd31, 6'd63, 6'd63);
        send_cmd(OP_MUX_TICK, 5'd0, 6'd0, 6'd0);
        send_cmd(OP_MUX_TICK, 5'd31, 6'd63, 6'd63);
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        logic [2:0] op;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
                op = OP_MUX_TICK;
            else if (pick < 88)
                op = OP_SECOND_TICK;
            else if (pick < 92)
                op = OP_SET_TIME;
            else if (pick < 95)
                op = OP_HOUR_BUTTON;
            else if (pick < 97)
                op = OP_MIN_BUTTON;
            else
                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            send_cmd(op, 5'($urandom), 6'($urandom), 6'($urandom));
            if (op <= OP_MIN_BUTTON)
                sent++;
        end
    endtask

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall  = 1'b0;
                stall_left = pick_idle_len(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        display_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("anode_select", 8'(want.anode_select), 8'(anode_select));
                check_field("anode_on", 8'(want.anode_on), 8'(anode_on));
                check_field("cathode_code", 8'(want.cathode_code), 8'(cathode_code));
                check_field("hours", 8'(want.hours), 8'(hours));
                check_field("minutes", 8'(want.minutes), 8'(minutes));
                check_field("seconds", 8'(want.seconds), 8'(seconds));
                check_field("dot_on", 8'(want.dot_on), 8'(dot_on));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        operation   = OP_MUX_TICK;
        set_hours   = '0;
        set_minutes = '0;
        set_seconds = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_set_time_clamp();
        test_time_rollover();
        test_buttons();
        test_mux_ticks();
        test_random_traffic();

        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- nixie_clock_mux_driver.f -----
+incdir+sv
sv/nxc_pkg.sv
sv/nxc_time.sv
sv/nxc_display.sv
sv/nixie_clock_mux_driver.sv
sim/nixie_clock_mux_driver_tb.sv
